// File: rtl/mersenne_twister_generator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the generator's top-level RTL.
// ---------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("generator check failed in same cycle");

// Next-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("generator check failed one cycle later");

`endif

// File: rtl/mtg_pkg.sv
// ---------------------------------------------------------------------------
// mtg_pkg
// Constants and shared types of the MT19937 word generator.
// ---------------------------------------------------------------------------
package mtg_pkg;

	localparam int TABLE_WORDS_DEF   = 624;
	localparam int MIDDLE_OFFSET_DEF = 397;
	localparam int WORD_W            = 32;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t TWIST_MATRIX = 32'h9908_b0df;
	localparam word_t HIGH_BIT     = 32'h8000_0000;
	localparam word_t LOW_BITS     = 32'h7fff_ffff;
	localparam word_t TEMPER_B     = 32'h9d2c_5680;
	localparam word_t TEMPER_C     = 32'hefc6_0000;
	localparam word_t LCG_MULT     = 32'd69069;
	localparam word_t SCR_START    = 32'd373737;
	localparam word_t SCR_MULT     = 32'd5531;
	localparam word_t SCR_ADD      = 32'd81547;

	// Input word kinds.
	localparam logic KIND_DRAW   = 1'b0;
	localparam logic KIND_RESEED = 1'b1;

	// Fill stream from the seeder into the tail of the cell chain.
	typedef struct packed {
		logic  active;
		word_t word;
	} fill_t;

endpackage

// File: rtl/mtg_cell.sv
// ---------------------------------------------------------------------------
// mtg_cell
// One state word of the generator; takes its neighbour's word on a shift.
// ---------------------------------------------------------------------------
module mtg_cell
	import mtg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  word_t d,
	output word_t q
);

	word_t word_q;

	// The state table resets to zero, which the first draw must see.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// File: rtl/mtg_twist.sv
// ---------------------------------------------------------------------------
// mtg_twist
// Recurrence step of MT19937 and output tempering of the new word.
// ---------------------------------------------------------------------------
module mtg_twist
	import mtg_pkg::*;
(
	input  word_t head,
	input  word_t next,
	input  word_t mid,
	output word_t new_word,
	output word_t tempered
);

	word_t y;
	word_t t1;
	word_t t2;
	word_t t3;

	always_comb begin
		y        = (head & HIGH_BIT) | (next & LOW_BITS);
		new_word = mid ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
		t1       = new_word ^ (new_word >> 11);
		t2       = t1 ^ ((t1 << 7) & TEMPER_B);
		t3       = t2 ^ ((t2 << 15) & TEMPER_C);
		tempered = t3 ^ (t3 >> 18);
	end

endmodule

// File: rtl/mtg_seed.sv
// ---------------------------------------------------------------------------
// mtg_seed
// Produces the seeded table, one word per cycle, from the 69069 chain
// XORed with the scrambler sequence.
// ---------------------------------------------------------------------------
module mtg_seed
	import mtg_pkg::*;
#(
	parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t seed,
	output fill_t fill
);

	localparam int CNT_W = $clog2(TABLE_WORDS);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            lcg_q;
	word_t            scr_q;
	word_t            scr_mul;
	word_t            scr_next;
	logic             first;

	assign first    = (cnt_q == '0);
	assign scr_mul  = 32'(scr_q * SCR_MULT) + SCR_ADD;
	assign scr_next = scr_mul ^ (scr_mul >> 9) ^ (scr_mul << 19);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(TABLE_WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The first table word is the bare seed; the scrambler advances only
	// after it has been applied to a word.
	always_ff @(posedge clk) begin
		if (start) begin
			lcg_q <= seed;
			scr_q <= SCR_START;
		end else if (busy_q) begin
			lcg_q <= 32'(lcg_q * LCG_MULT);
			if (!first) begin
				scr_q <= scr_next;
			end
		end
	end

	assign fill.active = busy_q;
	assign fill.word   = lcg_q ^ (first ? '0 : scr_q);

endmodule

// File: rtl/mersenne_twister_generator.sv
// ---------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 word generator built as a circular row of state cells.
// ---------------------------------------------------------------------------
//  channel | signals                       | direction
//  --------+-------------------------------+-----------
//  in      | in_valid, in_stall, kind,     | into block
//          | seed_value                    |
//  out     | out_valid, out_stall,         | out of block
//          | random_word                   |
//
// A draw word is taken every cycle while in_stall is low: the head cells feed
// the twist unit, the new state word enters the tail and its tempered value is
// registered out. A reseed word starts a fill of TABLE_WORDS seeder words, one
// shifted in per cycle, with in_stall high throughout, so no further word is
// taken until the fill ends; it gives no output word.
// Reset zeroes every cell, which is the all-zero table; no clearing pass.
// A stalled output holds its word and stalls further input words.
// ---------------------------------------------------------------------------
`include "mersenne_twister_generator_defines.svh"

module mersenne_twister_generator
	import mtg_pkg::*;
#(
	parameter int TABLE_WORDS   = TABLE_WORDS_DEF,
	parameter int MIDDLE_OFFSET = MIDDLE_OFFSET_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  kind,
	input  word_t seed_value,
	output logic  out_valid,
	input  logic  out_stall,
	output word_t random_word
);

	word_t chain [TABLE_WORDS];
	fill_t fill;
	word_t twist_word;
	word_t tempered;
	word_t feed;
	logic  in_fire;
	logic  draw_fire;
	logic  seed_fire;
	logic  shift;
	logic  out_valid_q;
	word_t random_word_q;

	assign in_stall  = fill.active || (out_valid_q && out_stall);
	assign in_fire   = in_valid && !in_stall;
	assign draw_fire = in_fire && (kind == KIND_DRAW);
	assign seed_fire = in_fire && (kind == KIND_RESEED);
	assign shift     = fill.active || draw_fire;
	assign feed      = fill.active ? fill.word : twist_word;

	mtg_seed #(
		.TABLE_WORDS(TABLE_WORDS)
	) u_seed (
		.clk   (clk),
		.arst_n(arst_n),
		.start (seed_fire),
		.seed  (seed_value),
		.fill  (fill)
	);

	mtg_twist u_twist (
		.head    (chain[0]),
		.next    (chain[1]),
		.mid     (chain[MIDDLE_OFFSET]),
		.new_word(twist_word),
		.tempered(tempered)
	);

	// Cell 0 is the oldest word; words move towards it on every shift.
	for (genvar i = 0; i < TABLE_WORDS; i++) begin : g_cell
		if (i == TABLE_WORDS - 1) begin : g_tail
			mtg_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (shift),
				.d     (feed),
				.q     (chain[i])
			);
		end else begin : g_body
			mtg_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (shift),
				.d     (chain[i+1]),
				.q     (chain[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_fire) begin
			random_word_q <= tempered;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

	`MTG_ASSERT_NOW(a_fill_stalls_input, clk, arst_n, fill.active, in_stall)
	`MTG_ASSERT_NEXT(a_draw_gives_word, clk, arst_n, draw_fire, out_valid)
	`MTG_ASSERT_NEXT(a_reseed_starts_fill, clk, arst_n, seed_fire, fill.active)
	`MTG_ASSERT_NEXT(a_fill_keeps_output, clk, arst_n, fill.active, $stable(random_word_q))

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - mersenne_twister_generator testbench
// Draw and reseed words go through the valid/stall channels and every
// returned word is checked against a table-based model of the generator.
// A short table of directed words comes first, then about 2000 random words,
// most of them well-formed seed-and-draw runs, with random idling on both
// sides and a single long hold-off at the output.
// ---------------------------------------------------------------------------
module tb;
	import mtg_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 12;
	localparam int RANDOM_WORDS = 2000;
	localparam int QUIET_FROM  = 1800;
	localparam int HOLD_CYC    = 300;
	localparam int DRAIN_CYC   = 700;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int DIR_ROWS    = 21;

	typedef struct packed {
		logic  kind;
		word_t seed;
		logic  known;
		word_t known_word;
	} dir_row_t;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  in_valid   = 1'b0;
	logic  kind       = KIND_DRAW;
	word_t seed_value = '0;
	logic  out_stall  = 1'b0;
	logic  in_stall;
	logic  out_valid;
	word_t random_word;

	// Directed rows carry a typed-in result where one is obvious.
	logic  row_known      = 1'b0;
	word_t row_known_word = '0;

	// Model state.
	word_t       gen_table [TABLE_WORDS_DEF];
	logic [9:0]  gen_index;
	word_t       expected_words [$];

	int unsigned error_count   = 0;
	int unsigned draw_count    = 0;
	int unsigned reseed_count  = 0;
	int unsigned twist_count   = 0;
	int unsigned checked_count = 0;
	int unsigned cycle_count   = 0;
	int unsigned random_count  = 0;

	bit quiet      = 1'b0;
	bit hold_req   = 1'b0;
	bit rx_holding = 1'b0;
	bit tx_idle_en = 1'b1;
	int unsigned tx_phase_left = 0;

	dir_row_t dir_rows [DIR_ROWS];

	mersenne_twister_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

	always #CLK_HALF clk = ~clk;

	function automatic word_t temper_word(input word_t raw);
		word_t y;
		y = raw;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	task automatic twist_gen_table();
		int    nxt;
		int    mid;
		word_t y;
		for (int k = 0; k < TABLE_WORDS_DEF; k++) begin
			nxt = (k + 1) % TABLE_WORDS_DEF;
			mid = (k + MIDDLE_OFFSET_DEF) % TABLE_WORDS_DEF;
			y = (gen_table[k] & HIGH_BIT) | (gen_table[nxt] & LOW_BITS);
			gen_table[k] = gen_table[mid] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : word_t'(0));
		end
		twist_count++;
	endtask

	task automatic reseed_gen_table(input word_t seed);
		word_t s;
		s = SCR_START;
		gen_table[0] = seed;
		for (int k = 1; k < TABLE_WORDS_DEF; k++)
			gen_table[k] = word_t'(LCG_MULT * gen_table[k-1]);
		// The scrambler chain is folded into every entry but the first.
		for (int k = 1; k < TABLE_WORDS_DEF; k++) begin
			gen_table[k] = gen_table[k] ^ s;
			s = word_t'(s * SCR_MULT + SCR_ADD);
			s = s ^ (s >> 9) ^ word_t'(s << 19);
		end
		gen_index = 10'(TABLE_WORDS_DEF);
	endtask

	task automatic draw_next_word(output word_t w);
		if (gen_index >= 10'(TABLE_WORDS_DEF)) begin
			twist_gen_table();
			gen_index = '0;
		end
		w = temper_word(gen_table[gen_index]);
		gen_index = gen_index + 10'd1;
	endtask

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("[%0t] mismatch: %s got %08h expected %08h", $time, what, got, want);
		error_count++;
	endtask

	// Scoreboard: outputs first, since a word leaving now was predicted earlier.
	always @(posedge clk) begin : scoreboard
		word_t want;
		word_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected random_word", random_word, '0);
				end else begin
					want = expected_words.pop_front();
					if (random_word !== want)
						report_mismatch("random_word", random_word, want);
					checked_count++;
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_RESEED) begin
					reseed_gen_table(seed_value);
					reseed_count++;
				end else begin
					draw_next_word(w);
					expected_words.push_back(row_known ? row_known_word : w);
					draw_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, expected_words.size());
			$display("** mersenne_twister_generator: FAILED **");
			$finish;
		end
	end

	// Receiver: random stall bursts, stretches with none, and one long hold.
	always @(negedge clk) begin : receiver
		static int unsigned hold_left  = 0;
		static int unsigned burst_left = 0;
		static int unsigned phase_left = 0;
		static bit          hold_done  = 1'b0;
		static bit          stall_en   = 1'b1;
		if (phase_left == 0) begin
			phase_left = $urandom_range(50, 300);
			stall_en = ($urandom_range(0, 2) != 0);
		end else begin
			phase_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			rx_holding = (hold_left > 0);
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYC - 1;
			rx_holding = 1'b1;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (!quiet && stall_en && $urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// One word per call; valid stays high across back-to-back words.
	task automatic send_word(input logic k, input word_t s, input logic known,
			input word_t known_w);
		int unsigned gap;
		gap = 0;
		if (tx_phase_left == 0) begin
			tx_phase_left = $urandom_range(40, 250);
			tx_idle_en = ($urandom_range(0, 2) != 0);
		end else begin
			tx_phase_left--;
		end
		if (!quiet && tx_idle_en && !rx_holding && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			kind <= 1'($urandom_range(0, 1));
			seed_value <= $urandom();
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		seed_value <= s;
		row_known <= known;
		row_known_word <= known_w;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic word_t pick_seed();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random(input logic k, input word_t s);
		send_word(k, s, 1'b0, '0);
		random_count++;
		quiet = (random_count >= QUIET_FROM);
	endtask

	initial begin : stimulus
		int unsigned n;
		dir_rows = '{
			// Before any reseed the all-zero table yields zero words.
			'{KIND_DRAW,   32'h0000_0000, 1'b1, 32'h0},
			'{KIND_DRAW,   32'hffff_ffff, 1'b1, 32'h0},
			'{KIND_DRAW,   32'h5a5a_5a5a, 1'b1, 32'h0},
			'{KIND_RESEED, 32'h0000_0000, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h0000_0000, 1'b0, 32'h0},
			'{KIND_DRAW,   32'hffff_ffff, 1'b0, 32'h0},
			'{KIND_RESEED, 32'hffff_ffff, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h0000_0000, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h0000_0000, 1'b0, 32'h0},
			// Back-to-back reseeds: only the second seed should count.
			'{KIND_RESEED, 32'h0000_0001, 1'b0, 32'h0},
			'{KIND_RESEED, 32'h8000_0000, 1'b0, 32'h0},
			'{KIND_DRAW,   32'hffff_ffff, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h1234_5678, 1'b0, 32'h0},
			'{KIND_RESEED, 32'd5489,      1'b0, 32'h0},
			'{KIND_DRAW,   32'h0000_0000, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h0000_0000, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h0000_0000, 1'b0, 32'h0},
			'{KIND_RESEED, 32'h7fff_ffff, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h0000_0000, 1'b0, 32'h0},
			'{KIND_RESEED, 32'haaaa_aaaa, 1'b0, 32'h0},
			'{KIND_DRAW,   32'h5555_5555, 1'b0, 32'h0}
		};
		for (int k = 0; k < TABLE_WORDS_DEF; k++)
			gen_table[k] = '0;
		gen_index = 10'(TABLE_WORDS_DEF);

		repeat (RESET_CYC) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			send_word(dir_rows[r].kind, dir_rows[r].seed, dir_rows[r].known,
				dir_rows[r].known_word);

		// First random run is long enough to force a twist, and it goes on
		// offering words while the output is held off so the block backs up.
		hold_req = 1'b1;
		send_random(KIND_RESEED, pick_seed());
		repeat (700) send_random(KIND_DRAW, $urandom());

		while (random_count < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0) begin
				// Noise: stray draws or a short burst of reseeds.
				n = $urandom_range(1, 3);
				repeat (n) send_random(1'($urandom_range(0, 1)), pick_seed());
			end else begin
				if ($urandom_range(0, 5) != 0)
					send_random(KIND_RESEED, pick_seed());
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(620, 1300)
					: $urandom_range(1, 80);
				repeat (n) send_random(KIND_DRAW, $urandom());
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Run covered %0d draws, %0d reseeds and %0d table twists; %0d words checked.",
			draw_count, reseed_count, twist_count, checked_count);
		$display("Idling on both channels and one %0d-cycle output hold-off were exercised.",
			HOLD_CYC);
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("** mersenne_twister_generator: PASSED **");
		end else begin
			$display("%0d mismatches, %0d words outstanding", error_count,
				expected_words.size());
			$display("** mersenne_twister_generator: FAILED **");
		end
		$finish;
	end

endmodule
